// ===== hw/rtl/id_buffer_edge_outline_unit_defines.svh =====
// ============================================================================
// Outline unit assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ============================================================================
`ifndef ID_BUFFER_EDGE_OUTLINE_UNIT_DEFINES_SVH
`define ID_BUFFER_EDGE_OUTLINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is high
`define IBEO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, active in every cycle
`define IBEO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBEO_ASSERT(lbl, clk, rst, prop, msg)
`define IBEO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/ibeo_pkg.sv =====
// ============================================================================
// Outline unit package
// Field widths, constants and the item format passed from front to back.
// ============================================================================
package ibeo_pkg;

  // stream field widths
  localparam int ID_W    = 32;
  localparam int COLOR_W = 32;
  localparam int PIX_W   = 10;

  // configuration register width and APB port sizing
  localparam int DIM_W      = 11;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // at most three results per input pixel: above, left, self
  localparam int NUM_RES = 3;

  // front-to-back queue depth
  localparam int QUEUE_DEPTH = 4;

  // opaque black for outline pixels
  localparam logic [COLOR_W-1:0] EDGE_COLOR = 32'hFF00_0000;

  // frame geometry as written over APB
  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  // one queue item: the results caused by one input pixel
  typedef struct packed {
    logic [NUM_RES-1:0]              res_valid;
    logic [NUM_RES-1:0]              is_edge;
    logic [NUM_RES-1:0][COLOR_W-1:0] color;
    logic [PIX_W-1:0]                px;
    logic [PIX_W-1:0]                py;
  } res_entry_t;

endpackage

// ===== hw/rtl/ibeo_if.sv =====
// ============================================================================
// Outline unit stream interfaces
// Valid/ready channels for input pixels and emitted result pixels.
// ============================================================================

// input pixel channel
interface ibeo_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [ibeo_pkg::ID_W-1:0]    object_id;
  logic [ibeo_pkg::COLOR_W-1:0] shaded_color;

  modport source (output valid, output object_id, output shaded_color, input ready);
  modport sink   (input valid, input object_id, input shaded_color, output ready);
endinterface

// result pixel channel
interface ibeo_result_if;
  logic                        valid;
  logic                        ready;
  logic [ibeo_pkg::COLOR_W-1:0] out_color;
  logic                        is_edge;
  logic [ibeo_pkg::PIX_W-1:0]   pixel_x;
  logic [ibeo_pkg::PIX_W-1:0]   pixel_y;
  logic                        last_of_run;
  logic                        frame_done;

  modport source (output valid, output out_color, output is_edge, output pixel_x,
                  output pixel_y, output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input out_color, input is_edge, input pixel_x,
                  input pixel_y, input last_of_run, input frame_done, output ready);
endinterface

// ===== hw/rtl/ibeo_front.sv =====
// ============================================================================
// Outline unit front end
// Accepts pixels, tracks raster position, keeps the id line buffers and the
// pending color row, and classifies every result an input pixel causes.
// ============================================================================
module ibeo_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ibeo_pkg::cfg_t       cfg,
  ibeo_pixel_if.sink           pixel,
  input  logic                 full,
  output logic                 push,
  output ibeo_pkg::res_entry_t push_entry
);

  localparam int XW       = $clog2(MAX_WIDTH);
  localparam int YW       = $clog2(MAX_HEIGHT);
  localparam int XW1      = XW + 1;
  localparam int YW1      = YW + 1;
  localparam int ID_DEPTH = 2 ** XW1;

  logic [XW1-1:0] w_c;
  logic [YW1-1:0] h_c;
  logic [XW-1:0]  col;
  logic [YW-1:0]  row;
  logic [XW1-1:0] col_p1;
  logic [YW1-1:0] row_p1;
  logic           row_end;
  logic           last_row;
  logic [XW-1:0]  nx;
  logic [YW-1:0]  ny;
  logic           accept;

  logic [XW-1:0]  rx;
  logic [YW-1:0]  ry;
  logic [XW-1:0]  rx_p1;
  logic [XW1-1:0] ra;
  logic [XW1-1:0] rb;
  logic [XW1-1:0] wa;

  logic [ibeo_pkg::ID_W-1:0]    id_mem [ID_DEPTH];
  logic [ibeo_pkg::COLOR_W-1:0] color_mem [MAX_WIDTH];

  // prefetched store words for the current position
  logic [ibeo_pkg::ID_W-1:0]    rd_a;   // row above, column + 1
  logic [ibeo_pkg::ID_W-1:0]    rd_b;   // two rows above, this column
  logic [ibeo_pkg::COLOR_W-1:0] rd_c;   // pending color, this column

  // neighborhood history
  logic [ibeo_pkg::ID_W-1:0]    win0;        // row above, column - 1
  logic [ibeo_pkg::ID_W-1:0]    win1;        // row above, this column (col > 0)
  logic [ibeo_pkg::ID_W-1:0]    first_prev;  // row above, column 0
  logic [ibeo_pkg::ID_W-1:0]    h1;          // this row, column - 1
  logic [ibeo_pkg::ID_W-1:0]    h2;          // this row, column - 2
  logic [ibeo_pkg::COLOR_W-1:0] c1;          // this row color, column - 1
  logic [ibeo_pkg::ID_W-1:0]    p_0;

  logic e_up;
  logic e_left;
  logic e_self;

  // clamp geometry to 1..MAX
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_c = XW1'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      w_c = XW1'(MAX_WIDTH);
    end else begin
      w_c = XW1'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_c = YW1'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      h_c = YW1'(MAX_HEIGHT);
    end else begin
      h_c = YW1'(cfg.frame_height);
    end
  end

  // raster position and next position
  assign col_p1   = {1'b0, col} + XW1'(1);
  assign row_p1   = {1'b0, row} + YW1'(1);
  assign row_end  = col_p1 >= w_c;
  assign last_row = row_p1 >= h_c;
  assign nx       = row_end ? '0 : col_p1[XW-1:0];
  assign ny       = row_end ? (last_row ? '0 : row_p1[YW-1:0]) : row;

  assign pixel.ready = !full && !rst;
  assign accept      = pixel.valid && pixel.ready;

  // store addresses: reads look at the position the next pixel will have
  assign rx    = accept ? nx : col;
  assign ry    = accept ? ny : row;
  assign rx_p1 = rx + XW'(1);
  assign ra    = {~ry[0], rx_p1};
  assign rb    = {ry[0], rx};
  assign wa    = {row[0], col};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= nx;
      row <= ny;
    end
  end

  // line buffer and color row writes
  always_ff @(posedge clk) begin
    if (accept) begin
      id_mem[wa]     <= pixel.object_id;
      color_mem[col] <= pixel.shaded_color;
    end
  end

  // registered reads, write data forwarded on a same-address hit
  always_ff @(posedge clk) begin
    rd_a <= (accept && wa == ra) ? pixel.object_id : id_mem[ra];
    rd_b <= (accept && wa == rb) ? pixel.object_id : id_mem[rb];
    rd_c <= (accept && col == rx) ? pixel.shaded_color : color_mem[rx];
  end

  // neighborhood history, shifted once per pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      win0 <= p_0;
      win1 <= rd_a;
      h2   <= h1;
      h1   <= pixel.object_id;
      c1   <= pixel.shaded_color;
      if (col == '0) begin
        first_prev <= pixel.object_id;
      end
    end
  end

  assign p_0 = (col == '0) ? first_prev : win1;

  // pixel above (col, row - 1): neighbors left, right, up, and this pixel below
  assign e_up = (col != '0 && win0 != p_0)
             || (!row_end && rd_a != p_0)
             || (row > YW'(1) && rd_b != p_0)
             || ({1'b0, row} < h_c && pixel.object_id != p_0);

  // last row, pixel to the left: its left, this pixel on the right, up
  assign e_left = (col > XW'(1) && h2 != h1)
               || ({1'b0, col} < w_c && pixel.object_id != h1)
               || (row != '0 && win0 != h1);

  // last row, row end: this pixel against left and up
  assign e_self = (col != '0 && h1 != pixel.object_id)
               || (row != '0 && p_0 != pixel.object_id);

  // build the queue item
  always_comb begin
    push_entry.res_valid = {last_row && row_end, last_row && col != '0, row != '0};
    push_entry.is_edge   = {e_self, e_left, e_up};
    push_entry.color[0]  = e_up   ? ibeo_pkg::EDGE_COLOR : rd_c;
    push_entry.color[1]  = e_left ? ibeo_pkg::EDGE_COLOR : c1;
    push_entry.color[2]  = e_self ? ibeo_pkg::EDGE_COLOR : pixel.shaded_color;
    push_entry.px        = ibeo_pkg::PIX_W'(col);
    push_entry.py        = ibeo_pkg::PIX_W'(row);
  end

  assign push = accept && (push_entry.res_valid != '0);

endmodule

// ===== hw/rtl/ibeo_queue.sv =====
// ============================================================================
// Outline unit item queue
// Short register FIFO between the classifying front and the emitting back.
// ============================================================================
`include "id_buffer_edge_outline_unit_defines.svh"

module ibeo_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ibeo_pkg::res_entry_t push_entry,
  output logic                 full,
  output logic                 head_valid,
  output ibeo_pkg::res_entry_t head_entry,
  input  logic                 pop
);

  localparam int DEPTH = ibeo_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = PW + 1;

  ibeo_pkg::res_entry_t entries [DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_entry = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `IBEO_ASSERT(a_push_not_full, clk, rst, push |-> !full, "queue push while full")
  `IBEO_ASSERT(a_pop_not_empty, clk, rst, pop |-> head_valid, "queue pop while empty")
  `IBEO_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count above depth")

endmodule

// ===== hw/rtl/ibeo_back.sv =====
// ============================================================================
// Outline unit back end
// Walks the results of the head queue item in order and presents them one
// per cycle through the output register while the result side is ready.
// ============================================================================
`include "id_buffer_edge_outline_unit_defines.svh"

module ibeo_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  ibeo_pkg::res_entry_t head_entry,
  output logic                 pop,
  ibeo_result_if.source        result
);

  typedef enum logic [1:0] {
    RES_UP   = 2'd0,
    RES_LEFT = 2'd1,
    RES_SELF = 2'd2
  } res_slot_t;

  localparam int NR = ibeo_pkg::NUM_RES;

  logic [NR-1:0]                sent;
  logic [NR-1:0]                rem;
  logic [NR-1:0]                slot_bit;
  res_slot_t                    slot;
  logic                         is_last;
  logic                         load;
  logic [ibeo_pkg::PIX_W-1:0]   sel_x;
  logic [ibeo_pkg::PIX_W-1:0]   sel_y;

  // output register
  logic                         out_valid;
  logic [ibeo_pkg::COLOR_W-1:0] color;
  logic                         edge_flag;
  logic [ibeo_pkg::PIX_W-1:0]   pos_x;
  logic [ibeo_pkg::PIX_W-1:0]   pos_y;
  logic                         last;
  logic                         frame_end;

  // pick the next unsent result: above, then left, then self
  assign rem = head_entry.res_valid & ~sent;

  always_comb begin
    priority if (rem[RES_UP]) begin
      slot = RES_UP;
    end else if (rem[RES_LEFT]) begin
      slot = RES_LEFT;
    end else begin
      slot = RES_SELF;
    end
  end

  assign slot_bit = NR'(1) << slot;
  assign is_last  = (rem & ~slot_bit) == '0;
  assign load     = head_valid && (!out_valid || result.ready);
  assign pop      = load && is_last;

  // position of the selected result
  always_comb begin
    unique case (slot)
      RES_UP: begin
        sel_x = head_entry.px;
        sel_y = head_entry.py - ibeo_pkg::PIX_W'(1);
      end
      RES_LEFT: begin
        sel_x = head_entry.px - ibeo_pkg::PIX_W'(1);
        sel_y = head_entry.py;
      end
      RES_SELF: begin
        sel_x = head_entry.px;
        sel_y = head_entry.py;
      end
      default: begin
        sel_x = head_entry.px;
        sel_y = head_entry.py;
      end
    endcase
  end

  // control: output valid and sent mask of the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        sent <= '0;
      end else if (load) begin
        sent <= sent | slot_bit;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      color     <= head_entry.color[slot];
      edge_flag <= head_entry.is_edge[slot];
      pos_x     <= sel_x;
      pos_y     <= sel_y;
      last      <= is_last;
      frame_end <= slot == RES_SELF;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_color   = color;
  assign result.is_edge     = edge_flag;
  assign result.pixel_x     = pos_x;
  assign result.pixel_y     = pos_y;
  assign result.last_of_run = last;
  assign result.frame_done  = frame_end;

  `IBEO_ASSERT(a_head_has_work, clk, rst, head_valid |-> rem != '0, "head item with nothing left")
  `IBEO_ASSERT(a_pop_loads, clk, rst, pop |=> out_valid, "item retired without a result shown")
  `IBEO_ASSERT(a_done_is_last, clk, rst, out_valid && frame_end |-> last, "frame end not last of run")

endmodule

// ===== hw/rtl/id_buffer_edge_outline_unit.sv =====
// ============================================================================
// Object-id edge outline unit
// Marks pixels whose id differs from a 4-neighbor as opaque black, over a
// raster pixel stream, with APB-written frame geometry.
// ============================================================================
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  ---------------------------------------------
//  pixel     in   valid/ready    object_id, shaded_color
//  result    out  valid/ready    out_color, is_edge, pixel_x, pixel_y,
//                                last_of_run, frame_done
//  apb       in   psel/penable   paddr, pwdata -> frame_width, frame_height
//
//  One pixel per clock when not stalled; results pass through the queue and the output register.
//  Last-row pixels cause up to two results (three at the row end); the output
//  register retires one result per clock while the result side is ready, so the
//  4-item queue fills and the pixel side stalls for the extra cycles.
//  Reset is synchronous; line buffers are not cleared, only position counters,
//  queue, sent mask and output valid. Geometry resets to 1024 x 1024.
//  A stall on the result side backs up through the queue to pixel ready.
//
module id_buffer_edge_outline_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ibeo_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ibeo_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ibeo_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  ibeo_pixel_if.sink                      pixel,
  ibeo_result_if.source                   result
);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  ibeo_pkg::cfg_t       cfg;
  reg_index_t           reg_sel;
  logic                 wr_en;
  logic                 push;
  logic                 full;
  logic                 head_valid;
  logic                 pop;
  ibeo_pkg::res_entry_t push_entry;
  ibeo_pkg::res_entry_t head_entry;

  // APB register file
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= ibeo_pkg::DIM_W'(1024);
      cfg.frame_height <= ibeo_pkg::DIM_W'(1024);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[ibeo_pkg::DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[ibeo_pkg::DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = ibeo_pkg::APB_DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = ibeo_pkg::APB_DATA_W'(cfg.frame_height);
    endcase
  end

  // classify pixels
  ibeo_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel      (pixel),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouple front and back
  ibeo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  // emit results
  ibeo_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== sim/id_buffer_edge_outline_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Outline unit testbench
// Streams raster frames of object ids and colors into the outline unit. A
// local model predicts every emitted pixel, and each result is checked field
// by field. The run covers several frame geometries, geometry changes inside
// a frame, and idle and stall loads on both stream sides.
// ============================================================================
module id_buffer_edge_outline_unit_tb;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;

  // APB register map
  localparam logic [ibeo_pkg::APB_ADDR_W-1:0] FRAME_WIDTH_ADDR  = ibeo_pkg::APB_ADDR_W'(0);
  localparam logic [ibeo_pkg::APB_ADDR_W-1:0] FRAME_HEIGHT_ADDR = ibeo_pkg::APB_ADDR_W'(4);

  // one emitted pixel as seen on the result channel
  typedef struct packed {
    logic [ibeo_pkg::COLOR_W-1:0] out_color;
    logic                         is_edge;
    logic [ibeo_pkg::PIX_W-1:0]   pixel_x;
    logic [ibeo_pkg::PIX_W-1:0]   pixel_y;
    logic                         last_of_run;
    logic                         frame_done;
  } out_pixel_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ibeo_pkg::APB_ADDR_W-1:0] paddr;
  logic [ibeo_pkg::APB_DATA_W-1:0] pwdata;
  logic [ibeo_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  ibeo_pixel_if  pix_if ();
  ibeo_result_if res_if ();

  id_buffer_edge_outline_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pix_if),
    .result  (res_if)
  );

  // outline model state
  logic [ibeo_pkg::ID_W-1:0]    id_rows [2][MAX_W];
  logic [ibeo_pkg::COLOR_W-1:0] pending_colors [MAX_W];
  int unsigned                  next_col   = 0;
  int unsigned                  next_row   = 0;
  logic [ibeo_pkg::DIM_W-1:0]   width_reg  = ibeo_pkg::DIM_W'(1024);
  logic [ibeo_pkg::DIM_W-1:0]   height_reg = ibeo_pkg::DIM_W'(1024);
  out_pixel_t                   expected_pixels [$];

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int unsigned pixels_sent    = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Outline model
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(logic [ibeo_pkg::DIM_W-1:0] v,
                                            int unsigned maxv);
    if (v == 0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  // id at (nx, ny); the arriving pixel is not in the line store yet
  function automatic logic [ibeo_pkg::ID_W-1:0] id_at(int unsigned nx, int unsigned ny,
                                                      int unsigned cx, int unsigned cy,
                                                      logic [ibeo_pkg::ID_W-1:0] cur);
    if (nx == cx && ny == cy) return cur;
    return id_rows[ny & 1][nx % MAX_W];
  endfunction

  // any in-image 4-neighbor with a different id
  function automatic bit outline_at(int unsigned px, int unsigned py,
                                    int unsigned w, int unsigned h,
                                    int unsigned cx, int unsigned cy,
                                    logic [ibeo_pkg::ID_W-1:0] cur);
    logic [ibeo_pkg::ID_W-1:0] c;
    c = id_at(px, py, cx, cy, cur);
    if (px > 0 && id_at(px - 1, py, cx, cy, cur) != c) return 1'b1;
    if (px + 1 < w && id_at(px + 1, py, cx, cy, cur) != c) return 1'b1;
    if (py > 0 && id_at(px, py - 1, cx, cy, cur) != c) return 1'b1;
    if (py + 1 < h && id_at(px, py + 1, cx, cy, cur) != c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_pixel_t pack_pixel(logic [ibeo_pkg::COLOR_W-1:0] color,
                                            bit on_edge, int unsigned x,
                                            int unsigned y, bit done);
    out_pixel_t p;
    p.out_color   = on_edge ? ibeo_pkg::EDGE_COLOR : color;
    p.is_edge     = on_edge;
    p.pixel_x     = x[ibeo_pkg::PIX_W-1:0];
    p.pixel_y     = y[ibeo_pkg::PIX_W-1:0];
    p.last_of_run = 1'b0;
    p.frame_done  = done;
    return p;
  endfunction

  // results caused by one accepted pixel: row above, left neighbor, self
  function automatic void predict_outline(logic [ibeo_pkg::ID_W-1:0] id,
                                          logic [ibeo_pkg::COLOR_W-1:0] color);
    out_pixel_t  run [ibeo_pkg::NUM_RES];
    int unsigned w, h, x, y, n;
    bit          row_end, last_row;
    w        = clamp_dim(width_reg, MAX_W);
    h        = clamp_dim(height_reg, MAX_H);
    x        = next_col % MAX_W;
    y        = next_row % MAX_H;
    row_end  = (x + 1 >= w);
    last_row = (y + 1 >= h);
    n        = 0;
    if (y > 0) begin
      run[n] = pack_pixel(pending_colors[x], outline_at(x, y - 1, w, h, x, y, id),
                          x, y - 1, 1'b0);
      n++;
    end
    id_rows[y & 1][x] = id;
    if (last_row && x > 0) begin
      run[n] = pack_pixel(pending_colors[x - 1], outline_at(x - 1, y, w, h, x, y, id),
                          x - 1, y, 1'b0);
      n++;
    end
    pending_colors[x] = color;
    if (last_row && row_end) begin
      run[n] = pack_pixel(color, outline_at(x, y, w, h, x, y, id), x, y, 1'b1);
      n++;
    end
    if (n > 0) run[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(run[i]);
    // advance raster position
    if (row_end) begin
      next_col = 0;
      next_row = last_row ? 0 : y + 1;
    end else begin
      next_col = x + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [ibeo_pkg::APB_ADDR_W-1:0] addr,
                           input logic [ibeo_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == FRAME_WIDTH_ADDR) width_reg = data[ibeo_pkg::DIM_W-1:0];
    else if (addr == FRAME_HEIGHT_ADDR) height_reg = data[ibeo_pkg::DIM_W-1:0];
    @(posedge clk);
  endtask

  // one pixel item; valid stays high into the next item unless a gap is drawn
  task automatic send_pixel(input logic [ibeo_pkg::ID_W-1:0] id,
                            input logic [ibeo_pkg::COLOR_W-1:0] color);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid        <= 1'b1;
    pix_if.object_id    <= id;
    pix_if.shaded_color <= color;
    do @(posedge clk); while (!pix_if.ready);
    predict_outline(id, color);
    pixels_sent++;
  endtask

  // pixels with ids drawn from a small pool, so flat regions and edges both occur
  task automatic send_run(input int unsigned count);
    logic [ibeo_pkg::ID_W-1:0] pool [3];
    logic [ibeo_pkg::ID_W-1:0] cur_id;
    int unsigned               dice;
    foreach (pool[i]) pool[i] = $urandom();
    if ($urandom_range(3) == 0) pool[0] = '0;
    if ($urandom_range(3) == 0) pool[1] = '1;
    cur_id = pool[0];
    for (int unsigned p = 0; p < count; p++) begin
      dice = $urandom_range(99);
      if (dice < 4) cur_id = $urandom();
      else if (dice < 35) cur_id = pool[$urandom_range(2)];
      send_pixel(cur_id, $urandom());
    end
  endtask

  // one whole frame at the current geometry
  task automatic send_frame();
    send_run(clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H));
  endtask

  // sender idles until every expected pixel is out, then lets the pipe go quiet
  task automatic settle_block();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 1x1 frames: zero registers clamp to one, upper write bits are dropped,
  // id and color extremes
  task automatic test_single_pixel_frames();
    settle_block();
    apb_write(FRAME_WIDTH_ADDR, 32'd0);
    apb_write(FRAME_HEIGHT_ADDR, 32'd0);
    send_pixel('0, '0);
    send_pixel('1, '1);
    settle_block();
    apb_write(FRAME_WIDTH_ADDR, 32'hFFFF_F801);
    apb_write(FRAME_HEIGHT_ADDR, 32'h8000_0801);
    send_pixel(32'h5A5A_A5A5, 32'hA5A5_5A5A);
    settle_block();
  endtask

  // 3x3 frame with a lone center object: cross of edges, unmarked corners
  task automatic test_small_outline();
    logic [ibeo_pkg::ID_W-1:0] ground;
    ground = $urandom();
    apb_write(FRAME_WIDTH_ADDR, 32'd3);
    apb_write(FRAME_HEIGHT_ADDR, 32'd3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? ~ground : ground, $urandom());
    settle_block();
  endtask

  // geometry written inside a frame: counters keep going, row and frame end
  // at or beyond the new limits
  task automatic test_geometry_change_mid_frame();
    // shrink both dimensions at a row boundary
    apb_write(FRAME_WIDTH_ADDR, 32'd3);
    apb_write(FRAME_HEIGHT_ADDR, 32'd4);
    send_run(6);
    settle_block();
    apb_write(FRAME_HEIGHT_ADDR, 32'd3);
    apb_write(FRAME_WIDTH_ADDR, 32'd2);
    send_run(2);
    settle_block();
    // shrink width below the current column inside the last row
    apb_write(FRAME_WIDTH_ADDR, 32'd4);
    apb_write(FRAME_HEIGHT_ADDR, 32'd2);
    send_run(6);
    settle_block();
    apb_write(FRAME_WIDTH_ADDR, 32'd1);
    send_run(1);
    // following frame starts clean at the new width
    send_frame();
    settle_block();
  endtask

  // random frames under one handshake load
  task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                    input int unsigned budget);
    int unsigned start;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start          = pixels_sent;
    while (pixels_sent - start < budget) begin
      if ($urandom_range(9) < 7) begin
        settle_block();
        apb_write(FRAME_WIDTH_ADDR, ($urandom_range(11) == 0) ? 0 : $urandom_range(10, 1));
        apb_write(FRAME_HEIGHT_ADDR, ($urandom_range(11) == 0) ? 0 : $urandom_range(6, 1));
      end else if ($urandom_range(3) == 0) begin
        settle_block();
      end
      send_frame();
    end
    settle_block();
  endtask

  // geometry above the maximum clamps to it: the row or the frame stays open
  // until a smaller size closes it
  task automatic test_clamped_geometry();
    src_idle_pct   = 8;
    sink_stall_pct = 8;
    // width 2047 acts as the maximum width, one-row frame
    apb_write(FRAME_WIDTH_ADDR, 32'd2047);
    apb_write(FRAME_HEIGHT_ADDR, 32'd1);
    send_run(5);
    settle_block();
    apb_write(FRAME_WIDTH_ADDR, 32'd6);
    send_run(1);
    settle_block();
    // height 2047 acts as the maximum height, one-column frame
    apb_write(FRAME_WIDTH_ADDR, 32'd1);
    apb_write(FRAME_HEIGHT_ADDR, 32'd2047);
    send_run(3);
    settle_block();
    apb_write(FRAME_HEIGHT_ADDR, 32'd4);
    send_run(1);
    settle_block();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    pix_if.valid        <= 1'b0;
    pix_if.object_id    <= '0;
    pix_if.shaded_color <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_single_pixel_frames();
    test_small_outline();
    test_geometry_change_mid_frame();
    test_random_frames(0, 0, 50);
    test_random_frames(75, 0, 50);
    test_random_frames(0, 75, 50);
    test_random_frames(8, 8, 50);
    test_clamped_geometry();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result checker: each accepted item against the oldest expectation
  always @(posedge clk) begin
    out_pixel_t got, want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.out_color   = res_if.out_color;
      got.is_edge     = res_if.is_edge;
      got.pixel_x     = res_if.pixel_x;
      got.pixel_y     = res_if.pixel_y;
      got.last_of_run = res_if.last_of_run;
      got.frame_done  = res_if.frame_done;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result item at (%0d, %0d)", got.pixel_x, got.pixel_y);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.out_color !== want.out_color) begin
          $error("out_color: expected %h, got %h", want.out_color, got.out_color);
          mismatch_count++;
        end
        if (got.is_edge !== want.is_edge) begin
          $error("is_edge: expected %b, got %b", want.is_edge, got.is_edge);
          mismatch_count++;
        end
        if (got.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
          mismatch_count++;
        end
        if (got.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
          mismatch_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
          mismatch_count++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || psel || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ibeo_pkg.sv
hw/rtl/ibeo_if.sv
hw/rtl/ibeo_front.sv
hw/rtl/ibeo_queue.sv
hw/rtl/ibeo_back.sv
hw/rtl/id_buffer_edge_outline_unit.sv
sim/id_buffer_edge_outline_unit_tb.sv
